// File: hw/rtl/sbmq_pkg.sv
// Shared constants and request/status codes for the shared-buffer multi-queue.
`timescale 1ns / 1ps

package sbmq_pkg;

	localparam int DATA_W     = 32;
	localparam int QNUM_W     = 2;
	localparam int IN_TDATA_W = 40;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

endpackage

// File: hw/rtl/shared_buffer_multi_queue_core.sv
// Top level of the shared-buffer multi-queue: request control, free list and result register.
`timescale 1ns / 1ps

// Channel   Direction  Fields (tdata low bit up)                 tuser
// s_axis    in         queue_num[1:0], data_in[33:2], pad to 40   req_type (0 enq, 1 deq)
// m_axis    out        data_out[31:0]                            status (0 ok, 1 ovf, 2 udf)
//
// An enqueue, or a request that is refused, loads its result after the queue table read,
// and a dequeue that finds data loads it after a further read: the queue table memory is
// read first, and such a dequeue then reads the slot memory at the head slot it got, each
// read being registered. Requests are worked one at a time; s_axis_tready is high only
// while no request is in progress, so a new request is taken only once the last one has
// loaded its result.
// The result register lets a new request in while a result waits.
// Reset needs no clearing pass: slots never handed out are tracked by a fill mark.
// A stalled m_axis holds the finishing request, and no state changes until it goes.

module shared_buffer_multi_queue_core
	import sbmq_pkg::*;
#(
	parameter int NUM_QUEUES  = 4,
	parameter int STORE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // queue_num[1:0], data_in[33:2], zero pad
	input  logic                  s_axis_tuser,  // req_type
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [DATA_W-1:0]     m_axis_tdata,  // data_out[31:0]
	output logic [1:0]            m_axis_tuser   // status[1:0]
);

	localparam int SW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

	localparam logic [1:0] FSM_IDLE = 2'd0;
	localparam logic [1:0] FSM_QRD  = 2'd1;
	localparam logic [1:0] FSM_LRD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;

	// Request held while it is worked on.
	logic              req_deq_q;
	logic              req_qvalid_q;
	logic [QW-1:0]     req_idx_q;
	logic [DATA_W-1:0] req_data_q;

	// Free list: head slot, number of free slots, and the fill mark below which
	// slots have been handed out at least once. Slots at or above the mark still
	// chain in order, so their link is their own index plus one.
	logic [SW-1:0] free_head_q;
	logic [SW:0]   free_cnt_q;
	logic [SW:0]   fresh_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [1:0]        out_status_q;

	logic [QNUM_W-1:0] in_qnum;
	logic              in_qvalid;
	logic              accept;
	logic              out_free;

	logic              sm_rd_en;
	logic [SW-1:0]     sm_rd_addr;
	logic [DATA_W-1:0] sm_rd_data;
	logic [SW-1:0]     sm_rd_link;
	logic              sm_link_wr_en;
	logic [SW-1:0]     sm_link_wr_addr;

	logic [SW-1:0] qt_rd_head;
	logic [SW-1:0] qt_rd_tail;
	logic          qt_ne;
	logic          qt_wr_en;
	logic [SW-1:0] qt_wr_head;
	logic [SW-1:0] qt_wr_tail;

	logic          fresh_hit;
	logic [SW-1:0] link_next;
	logic          need_lrd;
	logic          enq_commit;
	logic          deq_commit;
	logic          deq_last;
	logic          res_load;
	logic [DATA_W-1:0] res_data;
	logic [1:0]    res_status;

	assign in_qnum   = s_axis_tdata[QNUM_W-1:0];
	assign in_qvalid = ({5'd0, in_qnum} < 7'(NUM_QUEUES));

	assign s_axis_tready = (state_q == FSM_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_valid_q | m_axis_tready;

	// Link of the free head: from memory once the slot has been used, else the
	// next slot in index order.
	assign fresh_hit = ({1'b0, free_head_q} >= fresh_q);
	assign link_next = fresh_hit ? (free_head_q + SW'(1)) : sm_rd_link;

	assign need_lrd   = (state_q == FSM_QRD) & req_qvalid_q & (req_deq_q == REQ_DEQ) & qt_ne;
	assign enq_commit = (state_q == FSM_QRD) & req_qvalid_q & (req_deq_q == REQ_ENQ) &
	                    (free_cnt_q != '0) & out_free;
	assign deq_commit = (state_q == FSM_LRD) & out_free;
	assign deq_last   = (qt_rd_head == qt_rd_tail);
	assign res_load   = ((state_q == FSM_QRD) & !need_lrd & out_free) | deq_commit;

	// The enqueue reads the link of the free head right at acceptance; a dequeue
	// reads value and link of its head slot once the queue table has answered.
	assign sm_rd_en   = (accept & (s_axis_tuser == REQ_ENQ)) | need_lrd;
	assign sm_rd_addr = (state_q == FSM_IDLE) ? free_head_q : qt_rd_head;

	// An enqueue links the new slot behind the old tail; a dequeue pushes the
	// head slot onto the free list. Both write the free head as the link.
	assign sm_link_wr_en   = (enq_commit & qt_ne) | deq_commit;
	assign sm_link_wr_addr = deq_commit ? qt_rd_head : qt_rd_tail;

	assign qt_wr_en   = enq_commit | deq_commit;
	assign qt_wr_head = deq_commit ? sm_rd_link : (qt_ne ? qt_rd_head : free_head_q);
	assign qt_wr_tail = deq_commit ? qt_rd_tail : free_head_q;

	always_comb begin
		res_data   = '0;
		res_status = ST_OK;
		if (state_q == FSM_LRD) begin
			res_data = sm_rd_data;
		end else if (!req_qvalid_q) begin
			res_status = (req_deq_q == REQ_DEQ) ? ST_UNDERFLOW : ST_OVERFLOW;
		end else if (req_deq_q == REQ_DEQ) begin
			res_status = ST_UNDERFLOW;
		end else if (free_cnt_q == '0) begin
			res_status = ST_OVERFLOW;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_next = FSM_QRD;
				end
			end
			FSM_QRD: begin
				if (need_lrd) begin
					state_next = FSM_LRD;
				end else if (out_free) begin
					state_next = FSM_IDLE;
				end
			end
			FSM_LRD: begin
				if (out_free) begin
					state_next = FSM_IDLE;
				end
			end
			default: begin
				state_next = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			free_head_q <= '0;
			free_cnt_q  <= (SW+1)'(STORE_DEPTH);
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (enq_commit) begin
				free_head_q <= link_next;
				free_cnt_q  <= free_cnt_q - 1'b1;
				if (fresh_hit) begin
					fresh_q <= fresh_q + 1'b1;
				end
			end else if (deq_commit) begin
				free_head_q <= qt_rd_head;
				free_cnt_q  <= free_cnt_q + 1'b1;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_deq_q    <= s_axis_tuser;
			req_qvalid_q <= in_qvalid;
			req_idx_q    <= QW'(in_qnum);
			req_data_q   <= s_axis_tdata[QNUM_W +: DATA_W];
		end
		if (res_load) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

	sbmq_slot_mem #(
		.STORE_DEPTH(STORE_DEPTH),
		.SW         (SW)
	) u_slot_mem (
		.clk         (clk),
		.rd_en       (sm_rd_en),
		.rd_addr     (sm_rd_addr),
		.rd_data     (sm_rd_data),
		.rd_link     (sm_rd_link),
		.data_wr_en  (enq_commit),
		.data_wr_addr(free_head_q),
		.data_wr_data(req_data_q),
		.link_wr_en  (sm_link_wr_en),
		.link_wr_addr(sm_link_wr_addr),
		.link_wr_data(free_head_q)
	);

	sbmq_qtab #(
		.NUM_QUEUES(NUM_QUEUES),
		.QW        (QW),
		.SW        (SW)
	) u_qtab (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(QW'(in_qnum)),
		.rd_head(qt_rd_head),
		.rd_tail(qt_rd_tail),
		.ne_addr(req_idx_q),
		.ne     (qt_ne),
		.wr_en  (qt_wr_en),
		.wr_addr(req_idx_q),
		.wr_head(qt_wr_head),
		.wr_tail(qt_wr_tail),
		.ne_set (enq_commit),
		.ne_clr (deq_commit & deq_last)
	);

	// The free count never exceeds the store, and the fill mark never passes it.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(free_cnt_q <= (SW+1)'(STORE_DEPTH)) && (fresh_q <= (SW+1)'(STORE_DEPTH)))
		else $error("free list count or fill mark out of range");

	// A successful enqueue takes exactly one slot off the free list.
	a_enq_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		enq_commit |=> (free_cnt_q == $past(free_cnt_q) - 1'b1))
		else $error("enqueue did not take one free slot");

	// A successful dequeue returns exactly one slot to the free list.
	a_deq_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		deq_commit |=> (free_cnt_q == $past(free_cnt_q) + 1'b1))
		else $error("dequeue did not return one free slot");

	// Overflow is reported only for a full store or a nonexistent queue.
	a_ovf_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && (res_status == ST_OVERFLOW)) |-> (!req_qvalid_q || (free_cnt_q == '0)))
		else $error("overflow reported with free slots left");

	// The second read phase is entered only for a dequeue from a valid queue.
	a_lrd_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_LRD) |-> (req_qvalid_q && (req_deq_q == REQ_DEQ)))
		else $error("head read phase without a valid dequeue");

endmodule

// File: hw/rtl/sbmq_slot_mem.sv
// Slot storage: value memory and next-slot link memory sharing one read address.
`timescale 1ns / 1ps

module sbmq_slot_mem
	import sbmq_pkg::*;
#(
	parameter int STORE_DEPTH = 16,
	parameter int SW          = 4
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [SW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data,
	output logic [SW-1:0]     rd_link,
	input  logic              data_wr_en,
	input  logic [SW-1:0]     data_wr_addr,
	input  logic [DATA_W-1:0] data_wr_data,
	input  logic              link_wr_en,
	input  logic [SW-1:0]     link_wr_addr,
	input  logic [SW-1:0]     link_wr_data
);

	logic [DATA_W-1:0] data_mem [STORE_DEPTH];
	logic [SW-1:0]     link_mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (data_wr_en) begin
			data_mem[data_wr_addr] <= data_wr_data;
		end
		if (rd_en) begin
			rd_data <= data_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_wr_en) begin
			link_mem[link_wr_addr] <= link_wr_data;
		end
		if (rd_en) begin
			rd_link <= link_mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/sbmq_qtab.sv
// Per-queue table: head and tail slot memory plus nonempty flags in flip-flops.
`timescale 1ns / 1ps

module sbmq_qtab #(
	parameter int NUM_QUEUES = 4,
	parameter int QW         = 2,
	parameter int SW         = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [QW-1:0] rd_addr,
	output logic [SW-1:0] rd_head,
	output logic [SW-1:0] rd_tail,
	input  logic [QW-1:0] ne_addr,
	output logic          ne,
	input  logic          wr_en,
	input  logic [QW-1:0] wr_addr,
	input  logic [SW-1:0] wr_head,
	input  logic [SW-1:0] wr_tail,
	input  logic          ne_set,
	input  logic          ne_clr
);

	logic [SW-1:0]         head_mem [NUM_QUEUES];
	logic [SW-1:0]         tail_mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] ne_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			head_mem[wr_addr] <= wr_head;
			tail_mem[wr_addr] <= wr_tail;
		end
		if (rd_en) begin
			rd_head <= head_mem[rd_addr];
			rd_tail <= tail_mem[rd_addr];
		end
	end

	// The head and tail of a queue are used only while its flag is set, and the
	// flag is set only together with a write of both, so the memory needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
		end else if (ne_set) begin
			ne_q[wr_addr] <= 1'b1;
		end else if (ne_clr) begin
			ne_q[wr_addr] <= 1'b0;
		end
	end

	assign ne = ne_q[ne_addr];

endmodule
